FILE: rtl/rau_pkg.sv
package rau_pkg;

   localparam int ValueWidthDefault = 32;
   localparam int QueueDepth        = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DIV = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_SUM,
      S_CHECK,
      S_G_SHIFT,
      S_G_ODDU,
      S_G_ODDV,
      S_G_STEP,
      S_DIV_NUM,
      S_DIV_DEN,
      S_PACK,
      S_OUT
   } exec_state_type;

endpackage

FILE: rtl/rational_arithmetic_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  op, a/b numerator and denominator
// rsp_      out        rsp_valid / rsp_stall  result numerator, denominator, status
//
// An item that leaves the queue runs through the multiplies to a check; one with a zero
// division or a zero numerator goes straight to packing, any other passes the
// iterative binary gcd and two bit-serial divides of 2*VALUE_WIDTH+1 steps each.
// Reset is synchronous and active high; it empties the queue and the sequencer.
// A two-entry queue keeps accepting while the back end works; the back end takes
// no new transaction until its result has been accepted past rsp_stall.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_a_numerator,
   input  logic [31:0] req_a_denominator,
   input  logic [31:0] req_b_numerator,
   input  logic [31:0] req_b_denominator,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_numerator,
   output logic [30:0] rsp_result_denominator,
   output logic [1:0]  rsp_status
);

   logic                   q_valid, q_pop, q_zero_div;
   op_type                 q_op;
   logic [VALUE_WIDTH-1:0] q_an, q_ad, q_bn, q_bd;

   rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_a_numerator,
      .req_a_denominator, .req_b_numerator, .req_b_denominator,
      .q_valid, .q_pop, .q_op, .q_zero_div, .q_an, .q_ad, .q_bn, .q_bd
   );

   rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_op, .q_zero_div, .q_an, .q_ad,
      .q_bn, .q_bd, .rsp_valid, .rsp_stall, .rsp_result_numerator,
      .rsp_result_denominator, .rsp_status
   );

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_OVERFLOW)) else $error("bad status code");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_result_numerator == '0 && rsp_result_denominator == '0))
      else $error("error result not zero");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> (rsp_result_denominator != '0))
      else $error("zero denominator on ok result");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/rau_front.sv
module rau_front
   import rau_pkg::*;
#(
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [31:0]            req_a_numerator,
   input  logic [31:0]            req_a_denominator,
   input  logic [31:0]            req_b_numerator,
   input  logic [31:0]            req_b_denominator,
   output logic                   q_valid,
   input  logic                   q_pop,
   output op_type                 q_op,
   output logic                   q_zero_div,
   output logic [VALUE_WIDTH-1:0] q_an,
   output logic [VALUE_WIDTH-1:0] q_ad,
   output logic [VALUE_WIDTH-1:0] q_bn,
   output logic [VALUE_WIDTH-1:0] q_bd
);

   localparam int EntryWidth = 3 + 4 * VALUE_WIDTH;
   localparam int PtrWidth   = $clog2(QueueDepth);

   logic [EntryWidth-1:0] entry_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;
   logic                  push;
   logic                  zero_div;
   logic [EntryWidth-1:0] head;

   // classify: flag a zero denominator, or a zero b numerator on a divide, up front
   always_comb begin
      zero_div = (req_a_denominator[VALUE_WIDTH-1:0] == '0)
              || (req_b_denominator[VALUE_WIDTH-1:0] == '0)
              || ((op_type'(req_op) == OP_DIV)
                  && (req_b_numerator[VALUE_WIDTH-1:0] == '0));
   end

   assign req_stall = (count_ff == (PtrWidth+1)'(QueueDepth));
   assign push      = req_valid && !req_stall;

   // advance queue pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {req_op, zero_div,
                                 req_a_numerator[VALUE_WIDTH-1:0],
                                 req_a_denominator[VALUE_WIDTH-1:0],
                                 req_b_numerator[VALUE_WIDTH-1:0],
                                 req_b_denominator[VALUE_WIDTH-1:0]};
      end
   end

   assign head    = entry_ff[rd_ptr_ff];
   assign q_valid = (count_ff != '0);
   assign q_op    = op_type'(head[EntryWidth-1 -: 2]);
   assign {q_zero_div, q_an, q_ad, q_bn, q_bd} = head[EntryWidth-3:0];

endmodule

FILE: rtl/rau_back.sv
module rau_back
   import rau_pkg::*;
#(
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  op_type                 q_op,
   input  logic                   q_zero_div,
   input  logic [VALUE_WIDTH-1:0] q_an,
   input  logic [VALUE_WIDTH-1:0] q_ad,
   input  logic [VALUE_WIDTH-1:0] q_bn,
   input  logic [VALUE_WIDTH-1:0] q_bd,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_result_numerator,
   output logic [30:0]            rsp_result_denominator,
   output logic [1:0]             rsp_status
);

   localparam int W   = VALUE_WIDTH;
   localparam int W2  = 2 * VALUE_WIDTH;
   localparam int W2P = 2 * VALUE_WIDTH + 1;
   localparam int SW  = $clog2(W2P + 1);

   exec_state_type state_ff, state_in;

   logic           an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff;
   logic [W-1:0]   ad_m_ff, bn_m_ff, bd_m_ff;
   op_type         op_ff;
   logic           zd_ff;
   logic [W-1:0]   ma_ff, mb_ff;
   logic [W2-1:0]  prod;
   logic [W2-1:0]  p1_ff, p2_ff;
   logic           p1_s_ff, p2_s_ff;
   logic [W2P-1:0] num_ff, den_ff;
   logic           num_s_ff, den_s_ff;
   logic [W2P-1:0] u_ff, v_ff;
   logic [SW-1:0]  shift_ff;
   logic [W2P-1:0] g_ff;
   logic [W2P-1:0] rem_ff, quo_ff, dvd_ff;
   logic [$clog2(W2P+1)-1:0] bit_ff;
   logic [W2P:0]   trial;
   logic [31:0]    res_num_ff;
   logic [30:0]    res_den_ff;
   status_type     res_st_ff;
   logic           rsp_valid_ff;
   logic           neg;
   logic [W2P-1:0] half;
   logic [31:0]    num_lo;

   assign q_pop     = (state_ff == S_IDLE) && q_valid && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign prod      = ma_ff * mb_ff;
   assign neg       = num_s_ff != den_s_ff;
   assign half      = W2P'(1) << (W - 1);
   assign trial     = {rem_ff, dvd_ff[W2P-1]} - {1'b0, g_ff};
   assign num_lo    = 32'(num_ff);

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // step the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (q_pop) state_in = S_MUL1;
         S_MUL1:    state_in = S_MUL2;
         S_MUL2:    state_in = S_MUL3;
         S_MUL3:    state_in = S_SUM;
         S_SUM:     state_in = S_CHECK;
         S_CHECK: begin
            if (zd_ff || den_ff == '0 || num_ff == '0) state_in = S_PACK;
            else state_in = S_G_SHIFT;
         end
         S_G_SHIFT: if (u_ff[0] || v_ff[0]) state_in = S_G_ODDU;
         S_G_ODDU:  if (u_ff[0]) state_in = S_G_ODDV;
         S_G_ODDV:  if (v_ff == '0) state_in = S_DIV_NUM;
                    else if (v_ff[0]) state_in = S_G_STEP;
         S_G_STEP:  state_in = S_G_ODDV;
         S_DIV_NUM: if (bit_ff == '0) state_in = S_DIV_DEN;
         S_DIV_DEN: if (bit_ff == '0) state_in = S_PACK;
         S_PACK:    state_in = S_OUT;
         S_OUT:     state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath: one multiply per cycle, then gcd, then two restoring divides, then pack
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            op_ff   <= q_op;
            zd_ff   <= q_zero_div;
            an_s_ff <= q_an[W-1];
            ad_s_ff <= q_ad[W-1];
            bn_s_ff <= q_bn[W-1];
            bd_s_ff <= q_bd[W-1];
            ad_m_ff <= mag_of(q_ad);
            bn_m_ff <= mag_of(q_bn);
            bd_m_ff <= mag_of(q_bd);
            ma_ff   <= mag_of(q_an);
            mb_ff   <= (q_op == OP_MUL) ? mag_of(q_bn) : mag_of(q_bd);
         end
         S_MUL1: begin
            p1_ff   <= prod;
            p1_s_ff <= (an_s_ff != ((op_ff == OP_MUL) ? bn_s_ff : bd_s_ff));
            ma_ff   <= (op_ff == OP_MUL || op_ff == OP_DIV) ? ad_m_ff : bn_m_ff;
            mb_ff   <= (op_ff == OP_MUL) ? bd_m_ff
                     : (op_ff == OP_DIV) ? bn_m_ff : ad_m_ff;
         end
         S_MUL2: begin
            p2_ff <= prod;
            if (op_ff == OP_MUL) p2_s_ff <= ad_s_ff != bd_s_ff;
            else if (op_ff == OP_DIV) p2_s_ff <= ad_s_ff != bn_s_ff;
            else p2_s_ff <= (bn_s_ff ^ (op_ff == OP_SUB)) != ad_s_ff;
            ma_ff <= ad_m_ff;
            mb_ff <= bd_m_ff;
         end
         S_MUL3: begin
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               den_ff   <= {1'b0, prod};
               den_s_ff <= 1'b0;
            end else begin
               den_ff   <= {1'b0, p2_ff};
               den_s_ff <= 1'b0;
            end
         end
         S_SUM: begin
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               if (p1_s_ff == p2_s_ff) begin
                  num_ff   <= {1'b0, p1_ff} + {1'b0, p2_ff};
                  num_s_ff <= p1_s_ff;
               end else if (p1_ff >= p2_ff) begin
                  num_ff   <= {1'b0, p1_ff - p2_ff};
                  num_s_ff <= p1_s_ff;
               end else begin
                  num_ff   <= {1'b0, p2_ff - p1_ff};
                  num_s_ff <= p2_s_ff;
               end
               den_s_ff <= ad_s_ff != bd_s_ff;
            end else begin
               num_ff   <= {1'b0, p1_ff};
               num_s_ff <= p1_s_ff;
               den_s_ff <= (op_ff == OP_MUL) ? (ad_s_ff != bd_s_ff)
                                             : (ad_s_ff != bn_s_ff);
            end
         end
         S_CHECK: begin
            u_ff     <= num_ff;
            v_ff     <= den_ff;
            shift_ff <= '0;
         end
         S_G_SHIFT: begin
            if (!(u_ff[0] || v_ff[0])) begin
               u_ff     <= u_ff >> 1;
               v_ff     <= v_ff >> 1;
               shift_ff <= shift_ff + 1'b1;
            end
         end
         S_G_ODDU: if (!u_ff[0]) u_ff <= u_ff >> 1;
         S_G_ODDV: begin
            if (v_ff == '0) begin
               g_ff   <= u_ff << shift_ff;
               dvd_ff <= num_ff;
               rem_ff <= '0;
               bit_ff <= ($clog2(W2P+1))'(W2P - 1);
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end
         end
         S_G_STEP: begin
            if (u_ff > v_ff) begin
               u_ff <= v_ff;
               v_ff <= u_ff - v_ff;
            end else begin
               v_ff <= v_ff - u_ff;
            end
         end
         S_DIV_NUM, S_DIV_DEN: begin
            if (bit_ff == '0 && state_ff == S_DIV_NUM) begin
               // hold the reduced numerator and start on the denominator
               num_ff <= {quo_ff[W2P-2:0], !trial[W2P]};
               dvd_ff <= den_ff;
               rem_ff <= '0;
               bit_ff <= ($clog2(W2P+1))'(W2P - 1);
            end else begin
               if (!trial[W2P]) begin
                  rem_ff <= trial[W2P-1:0];
                  quo_ff <= {quo_ff[W2P-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[W2P-2:0], dvd_ff[W2P-1]};
                  quo_ff <= {quo_ff[W2P-2:0], 1'b0};
               end
               dvd_ff <= dvd_ff << 1;
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  den_ff <= {quo_ff[W2P-2:0], !trial[W2P]};
               end
            end
         end
         S_PACK: begin
            res_num_ff <= '0;
            res_den_ff <= '0;
            if (zd_ff || den_ff == '0) begin
               res_st_ff <= ST_ZERO_DIV;
            end else if (num_ff == '0) begin
               res_st_ff  <= ST_OK;
               res_den_ff <= 31'd1;
            end else if (den_ff > half - 1'b1
                         || num_ff > (neg ? half : half - 1'b1)) begin
               res_st_ff <= ST_OVERFLOW;
            end else begin
               res_st_ff  <= ST_OK;
               res_num_ff <= neg ? (32'd0 - num_lo) : num_lo;
               res_den_ff <= 31'(den_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_result_numerator   = res_num_ff;
   assign rsp_result_denominator = res_den_ff;
   assign rsp_status             = res_st_ff;

endmodule
